### src/bmp_pixel_stream_decoder_top_macros.svh
`ifndef BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH
`define BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BMPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BMPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bmpd_pkg.sv
`default_nettype none

package bmpd_pkg;

    localparam int MAX_WIDTH_DEF       = 4096;
    localparam int MAX_HEIGHT_DEF      = 4096;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int ENTRY_W     = 32;

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_PALETTE = 2'd1,
        CMD_PIXEL   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_PAL8   = 2'd0,
        MODE_BGR24  = 2'd1,
        MODE_BGRA32 = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIXEL_MODE    = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_IMAGE_HEIGHT  = 3'd2,
        CFG_PAL_HAS_ALPHA = 3'd3,
        CFG_DEFAULT_ALPHA = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       pixel_mode;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             palette_has_alpha;
        logic [7:0]       default_alpha;
    } cfg_t;

    typedef struct packed {
        logic               is_pal;
        logic [1:0]         lane;
        logic [7:0]         data;
        logic               set_opaque;
        logic               use_palette;
        logic               pal_hit;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               done;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } req_t;

endpackage

`default_nettype wire

### src/bmpd_ram.sv
`default_nettype none

module bmpd_ram #(
    parameter int WIDTH = bmpd_pkg::ENTRY_W,
    parameter int DEPTH = bmpd_pkg::PALETTE_ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/bmpd_raster.sv
`default_nettype none

`include "bmp_pixel_stream_decoder_top_macros.svh"

module bmpd_raster #(
    parameter int MAX_WIDTH       = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = bmpd_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = bmpd_pkg::PALETTE_ENTRIES_DEF,
    localparam int AW             = $clog2(PALETTE_ENTRIES)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [1:0]      cmd,
    input  wire logic [7:0]      data_byte,
    input  wire bmpd_pkg::cfg_t  cfg,
    output logic                 req_valid,
    output bmpd_pkg::req_t       req,
    output logic [AW-1:0]        ram_addr
);

    localparam int DMAX    = (1 << bmpd_pkg::DIM_W) - 1;
    localparam int WMAX    = (MAX_WIDTH < DMAX) ? MAX_WIDTH : DMAX;
    localparam int HMAX    = (MAX_HEIGHT < DMAX) ? MAX_HEIGHT : DMAX;
    localparam int COL_W   = (WMAX > 1) ? $clog2(WMAX) : 1;
    localparam int ROW_W   = (HMAX > 1) ? $clog2(HMAX) : 1;
    localparam int XE_W    = COL_W + bmpd_pkg::COORD_W;
    localparam int YE_W    = ROW_W + bmpd_pkg::COORD_W;
    localparam int PC_W    = $clog2(PALETTE_ENTRIES * 4 + 1);
    localparam int PROD_W  = PC_W + 11;
    localparam int RECIP3  = 683;
    localparam int RSHIFT  = 11;
    localparam logic [PC_W-1:0] LIM4 = PC_W'(PALETTE_ENTRIES * 4);
    localparam logic [PC_W-1:0] LIM3 = PC_W'(PALETTE_ENTRIES * 3);

    logic [PC_W-1:0]  pal_cnt_reg, pal_cnt_next;
    logic [1:0]       bip_reg, bip_next;
    logic [23:0]      partial_reg, partial_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       pad_reg, pad_next;
    logic             fin_reg, fin_next;

    logic [bmpd_pkg::DIM_W-1:0] eff_w, eff_h, w_m1, h_m1;
    logic [PROD_W-1:0] prod3, entry3_full;
    logic [PC_W-1:0]   entry4_full, lane3_full;
    logic [AW-1:0]     pal_entry;
    logic [1:0]        pal_lane, last_byte, row_pad;
    logic [PC_W-1:0]   pal_limit;
    logic              col_last, do_next_row;
    logic [XE_W-1:0]   col_ext;
    logic [YE_W-1:0]   row_ext;

    always_comb begin
        if (cfg.image_width == '0) begin
            eff_w = bmpd_pkg::DIM_W'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            eff_w = bmpd_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = cfg.image_width;
        end
        if (cfg.image_height == '0) begin
            eff_h = bmpd_pkg::DIM_W'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            eff_h = bmpd_pkg::DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = cfg.image_height;
        end
    end

    assign w_m1     = eff_w - bmpd_pkg::DIM_W'(1);
    assign h_m1     = eff_h - bmpd_pkg::DIM_W'(1);
    assign col_last = (bmpd_pkg::DIM_W'(col_reg) >= w_m1);
    assign col_ext  = XE_W'(col_reg);
    assign row_ext  = YE_W'(row_reg);

    // palette byte position: count / 3 by reciprocal, count / 4 by shift
    assign prod3       = PROD_W'(pal_cnt_reg) * PROD_W'(RECIP3);
    assign entry3_full = prod3 >> RSHIFT;
    assign lane3_full  = pal_cnt_reg - (PC_W'(entry3_full) << 1) - PC_W'(entry3_full);
    assign entry4_full = pal_cnt_reg >> 2;

    always_comb begin
        if (cfg.palette_has_alpha) begin
            pal_entry = entry4_full[AW-1:0];
            pal_lane  = pal_cnt_reg[1:0];
            pal_limit = LIM4;
        end else begin
            pal_entry = entry3_full[AW-1:0];
            pal_lane  = lane3_full[1:0];
            pal_limit = LIM3;
        end
    end

    always_comb begin
        unique case (bmpd_pkg::mode_t'(cfg.pixel_mode))
            bmpd_pkg::MODE_PAL8: begin
                last_byte = 2'd0;
                row_pad   = 2'd0 - eff_w[1:0];
            end
            bmpd_pkg::MODE_BGR24: begin
                last_byte = 2'd2;
                row_pad   = eff_w[1:0];
            end
            default: begin
                last_byte = 2'd3;
                row_pad   = 2'd0;
            end
        endcase
    end

    always_comb begin
        pal_cnt_next = pal_cnt_reg;
        bip_next     = bip_reg;
        partial_next = partial_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        fin_next     = fin_reg;
        do_next_row  = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        req.data     = data_byte;
        ram_addr     = '0;

        if (accept) begin
            unique case (bmpd_pkg::cmd_t'(cmd))
                bmpd_pkg::CMD_RESTART: begin
                    pal_cnt_next = '0;
                    bip_next     = '0;
                    partial_next = '0;
                    col_next     = '0;
                    row_next     = h_m1[ROW_W-1:0];
                    pad_next     = '0;
                    fin_next     = 1'b0;
                end
                bmpd_pkg::CMD_PALETTE: begin
                    if (pal_cnt_reg < pal_limit) begin
                        req_valid      = 1'b1;
                        req.is_pal     = 1'b1;
                        req.lane       = pal_lane;
                        req.set_opaque = !cfg.palette_has_alpha && (pal_lane == 2'd0);
                        ram_addr       = pal_entry;
                        pal_cnt_next   = pal_cnt_reg + PC_W'(1);
                    end
                end
                bmpd_pkg::CMD_PIXEL: begin
                    if (fin_reg) begin
                        fin_next = fin_reg;
                    end else if (pad_reg != 2'd0) begin
                        pad_next    = pad_reg - 2'd1;
                        do_next_row = (pad_reg == 2'd1);
                    end else if (bip_reg < last_byte) begin
                        partial_next[bip_reg*8 +: 8] = data_byte;
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        req_valid = 1'b1;
                        unique case (bmpd_pkg::mode_t'(cfg.pixel_mode))
                            bmpd_pkg::MODE_PAL8: begin
                                req.use_palette = 1'b1;
                                req.pal_hit     = ({1'b0, data_byte} < 9'(PALETTE_ENTRIES));
                                ram_addr        = data_byte[AW-1:0];
                            end
                            bmpd_pkg::MODE_BGR24: begin
                                req.blue  = partial_reg[7:0];
                                req.green = partial_reg[15:8];
                                req.red   = data_byte;
                                req.alpha = cfg.default_alpha;
                            end
                            default: begin
                                req.blue  = partial_reg[7:0];
                                req.green = partial_reg[15:8];
                                req.red   = partial_reg[23:16];
                                req.alpha = data_byte;
                            end
                        endcase
                        bip_next     = '0;
                        partial_next = '0;
                        req.x        = col_ext[bmpd_pkg::COORD_W-1:0];
                        req.y        = row_ext[bmpd_pkg::COORD_W-1:0];
                        if (col_last) begin
                            req.done = (row_reg == '0);
                            if (row_pad == 2'd0) begin
                                do_next_row = 1'b1;
                            end else begin
                                pad_next = row_pad;
                            end
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                default: begin
                    fin_next = fin_reg;
                end
            endcase
        end

        if (do_next_row) begin
            col_next = '0;
            if (row_reg == '0) begin
                fin_next = 1'b1;
            end else begin
                row_next = row_reg - ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_cnt_reg <= '0;
            bip_reg     <= '0;
            partial_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
            fin_reg     <= 1'b0;
        end else begin
            pal_cnt_reg <= pal_cnt_next;
            bip_reg     <= bip_next;
            partial_reg <= partial_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            fin_reg     <= fin_next;
        end
    end

    `BMPD_ASSERT_NOW(a_fin_clean, aclk, aresetn, fin_reg, (bip_reg == 2'd0) && (pad_reg == 2'd0), "finished image left a pixel or padding open")
    `BMPD_ASSERT_NOW(a_pal_cnt_range, aclk, aresetn, 1'b1, pal_cnt_reg <= LIM4, "palette byte count beyond table")

endmodule

`default_nettype wire

### src/bmp_pixel_stream_decoder_top.sv
// pixel path: last byte accepted, then the lookup stage register, then the output register drives m_valid
// throughput: one byte per cycle while s_ready is high; the palette ram's registered read is the extra stage
// a stalled result blocks s_ready only while the lookup stage also holds a pixel
// reset: counters, restart state and pending words cleared, registers to defaults
// reset: palette contents undefined until loaded
`default_nettype none

`include "bmp_pixel_stream_decoder_top_macros.svh"

module bmp_pixel_stream_decoder_top #(
    parameter int MAX_WIDTH       = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = bmpd_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = bmpd_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bmpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bmpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_cmd,
    input  wire logic [7:0]                       s_data_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bmpd_pkg::COORD_W-1:0]          m_pixel_x,
    output logic [bmpd_pkg::COORD_W-1:0]          m_pixel_y,
    output logic [7:0]                            m_red,
    output logic [7:0]                            m_green,
    output logic [7:0]                            m_blue,
    output logic [7:0]                            m_alpha,
    output logic                                  m_image_done
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    bmpd_pkg::cfg_t cfg_reg;

    logic           accept;
    logic           req_valid;
    bmpd_pkg::req_t req;
    logic [AW-1:0]  ram_addr;
    logic [bmpd_pkg::ENTRY_W-1:0] ram_rdata;

    logic           s1_valid_reg;
    bmpd_pkg::req_t s1_req_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic           s1_go;
    logic           pal_we;

    logic                         fwd_valid_reg;
    logic [AW-1:0]                fwd_addr_reg;
    logic [bmpd_pkg::ENTRY_W-1:0] fwd_data_reg;
    logic [bmpd_pkg::ENTRY_W-1:0] base, merged;

    logic       out_load;
    logic       out_valid_reg;
    logic [bmpd_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic       out_done_reg;
    logic [7:0] pix_r, pix_g, pix_b, pix_a;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_mode        <= bmpd_pkg::MODE_BGR24;
            cfg_reg.image_width       <= bmpd_pkg::DIM_W'(1);
            cfg_reg.image_height      <= bmpd_pkg::DIM_W'(1);
            cfg_reg.palette_has_alpha <= 1'b1;
            cfg_reg.default_alpha     <= 8'hFF;
        end else if (cfg_wr_en) begin
            unique case (bmpd_pkg::cfg_idx_t'(cfg_index))
                bmpd_pkg::CFG_PIXEL_MODE:    cfg_reg.pixel_mode        <= cfg_wdata[1:0];
                bmpd_pkg::CFG_IMAGE_WIDTH:   cfg_reg.image_width       <= cfg_wdata;
                bmpd_pkg::CFG_IMAGE_HEIGHT:  cfg_reg.image_height      <= cfg_wdata;
                bmpd_pkg::CFG_PAL_HAS_ALPHA: cfg_reg.palette_has_alpha <= cfg_wdata[0];
                bmpd_pkg::CFG_DEFAULT_ALPHA: cfg_reg.default_alpha     <= cfg_wdata[7:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s1_go   = !s1_valid_reg || s1_req_reg.is_pal || !out_valid_reg || m_ready;
    assign s_ready = s1_go;
    assign accept  = s_valid && s_ready;

    bmpd_raster #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (s_cmd),
        .data_byte (s_data_byte),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .ram_addr  (ram_addr)
    );

    bmpd_ram #(
        .WIDTH (bmpd_pkg::ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s1_addr_reg),
        .wdata (merged),
        .re    (accept),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // lookup / read-modify-write stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s1_valid_reg <= accept && req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s1_req_reg  <= req;
            s1_addr_reg <= ram_addr;
        end
    end

    // entry written last cycle is not yet in the ram read data
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            base = fwd_data_reg;
        end else begin
            base = ram_rdata;
        end
        merged = base;
        merged[s1_req_reg.lane*8 +: 8] = s1_req_reg.data;
        if (s1_req_reg.set_opaque) begin
            merged[31:24] = 8'hFF;
        end
    end

    assign pal_we = s1_valid_reg && s1_req_reg.is_pal;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (pal_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= merged;
        end
    end

    always_comb begin
        if (!s1_req_reg.use_palette) begin
            pix_r = s1_req_reg.red;
            pix_g = s1_req_reg.green;
            pix_b = s1_req_reg.blue;
            pix_a = s1_req_reg.alpha;
        end else if (s1_req_reg.pal_hit) begin
            pix_b = base[7:0];
            pix_g = base[15:8];
            pix_r = base[23:16];
            pix_a = base[31:24];
        end else begin
            pix_r = 8'h00;
            pix_g = 8'h00;
            pix_b = 8'h00;
            pix_a = 8'h00;
        end
    end

    // output register
    assign out_load = s1_valid_reg && !s1_req_reg.is_pal && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= s1_req_reg.x;
            out_y_reg    <= s1_req_reg.y;
            out_r_reg    <= pix_r;
            out_g_reg    <= pix_g;
            out_b_reg    <= pix_b;
            out_a_reg    <= pix_a;
            out_done_reg <= s1_req_reg.done;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_x    = out_x_reg;
    assign m_pixel_y    = out_y_reg;
    assign m_red        = out_r_reg;
    assign m_green      = out_g_reg;
    assign m_blue       = out_b_reg;
    assign m_alpha      = out_a_reg;
    assign m_image_done = out_done_reg;

    `BMPD_ASSERT_NOW(a_stall_source, aclk, aresetn, !s_ready, s1_valid_reg && !s1_req_reg.is_pal && m_valid && !m_ready, "input stalled without a blocked pixel")
    `BMPD_ASSERT_NEXT(a_pal_write_done, aclk, aresetn, pal_we && !accept, !s1_valid_reg, "palette write lingered in lookup stage")
    `BMPD_ASSERT_NOW(a_done_top_row, aclk, aresetn, m_valid && m_image_done, m_pixel_y == '0, "image done off the top row")

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bmpd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int IDLE_MAX  = 15;
    localparam int HOLD_OFF  = 300;
    localparam int SETTLE    = 8;
    localparam int WORD_GOAL = 340;
    localparam int SHOW_MAX  = 10;
    localparam int LONG_RUN  = 400;
    localparam int DIM_ALL   = (1 << DIM_W) - 1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               done;
    } pixel_t;

    typedef struct {
        bit                     is_reg;
        logic [CFG_INDEX_W-1:0] idx;
        int unsigned            val;
        logic [1:0]             cmd;
        logic [7:0]             b;
        bit                     typed;
        bit                     has;
        pixel_t                 px;
    } row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_cmd;
    logic [7:0]             s_data_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [COORD_W-1:0]     m_pixel_x;
    logic [COORD_W-1:0]     m_pixel_y;
    logic [7:0]             m_red;
    logic [7:0]             m_green;
    logic [7:0]             m_blue;
    logic [7:0]             m_alpha;
    logic                   m_image_done;

    bmp_pixel_stream_decoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_image_done (m_image_done)
    );

    // decoder copy: registers, palette and image counters
    logic [1:0]       cur_mode;
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;
    logic             cur_pal_alpha;
    logic [7:0]       cur_def_alpha;

    bit [31:0]   pal_mem [PALETTE_ENTRIES_DEF];
    bit [3:0]    pal_lanes [PALETTE_ENTRIES_DEF];
    int unsigned full_idx [$];
    int unsigned pal_count;
    int unsigned lane_pos;
    logic [23:0] partial_bgr;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned pad_left;
    bit          image_over;

    pixel_t      want_q [$];
    row_t        plan_q [$];
    int unsigned words_sent;
    int unsigned pixels_seen;
    int unsigned frames_done;
    int unsigned mismatches;
    int unsigned phases;
    bit          hold_req;
    bit          calm;

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned bytes_per_px();
        case (cur_mode)
            MODE_PAL8:  return 1;
            MODE_BGR24: return 3;
            default:    return 4;
        endcase
    endfunction

    function automatic void restart_image();
        pal_count   = 0;
        lane_pos    = 0;
        partial_bgr = '0;
        col_cnt     = 0;
        row_cnt     = eff_dim(cur_height, MAX_HEIGHT_DEF) - 1;
        pad_left    = 0;
        image_over  = 1'b0;
    endfunction

    function automatic void end_row();
        col_cnt = 0;
        if (row_cnt == 0) begin
            image_over = 1'b1;
        end else begin
            row_cnt--;
        end
    endfunction

    function automatic void store_palette_byte(input logic [7:0] b);
        int unsigned per;
        int unsigned entry;
        int unsigned lane;
        bit was_full;
        per = cur_pal_alpha ? 4 : 3;
        if (pal_count >= PALETTE_ENTRIES_DEF * per) return;
        entry = pal_count / per;
        lane = pal_count % per;
        was_full = (pal_lanes[entry] == 4'hF);
        pal_mem[entry][8*lane +: 8] = b;
        pal_lanes[entry][lane] = 1'b1;
        if (!cur_pal_alpha && lane == 0) begin
            pal_mem[entry][31:24] = 8'hFF;
            pal_lanes[entry][3] = 1'b1;
        end
        if (!was_full && pal_lanes[entry] == 4'hF) full_idx.push_back(entry);
        pal_count++;
    endfunction

    function automatic bit decode_word(input logic [1:0] cmd, input logic [7:0] b,
                                       output pixel_t px);
        int unsigned bpp;
        int unsigned w;
        int unsigned pad;
        logic [31:0] e;
        px = '0;
        case (cmd)
            CMD_RESTART: begin
                restart_image();
                return 1'b0;
            end
            CMD_PALETTE: begin
                store_palette_byte(b);
                return 1'b0;
            end
            CMD_PIXEL: begin
            end
            default: return 1'b0;
        endcase
        if (image_over) return 1'b0;
        if (pad_left != 0) begin
            pad_left--;
            if (pad_left == 0) end_row();
            return 1'b0;
        end
        bpp = bytes_per_px();
        if (lane_pos < bpp - 1) begin
            partial_bgr[8*lane_pos +: 8] = b;
            lane_pos++;
            return 1'b0;
        end
        case (bpp)
            1: begin
                e = pal_mem[b];
                px.blue  = e[7:0];
                px.green = e[15:8];
                px.red   = e[23:16];
                px.alpha = e[31:24];
            end
            3: begin
                px.blue  = partial_bgr[7:0];
                px.green = partial_bgr[15:8];
                px.red   = b;
                px.alpha = cur_def_alpha;
            end
            default: begin
                px.blue  = partial_bgr[7:0];
                px.green = partial_bgr[15:8];
                px.red   = partial_bgr[23:16];
                px.alpha = b;
            end
        endcase
        lane_pos = 0;
        partial_bgr = '0;
        w = eff_dim(cur_width, MAX_WIDTH_DEF);
        px.x = col_cnt[COORD_W-1:0];
        px.y = row_cnt[COORD_W-1:0];
        px.done = 1'b0;
        if (col_cnt >= w - 1) begin
            px.done = (row_cnt == 0);
            pad = (4 - ((w * bpp) % 4)) % 4;
            if (pad == 0) begin
                end_row();
            end else begin
                pad_left = pad;
            end
        end else begin
            col_cnt++;
        end
        return 1'b1;
    endfunction

    // an 8-bit lookup only ever hits a fully loaded entry
    function automatic int unsigned safe_pixel_byte();
        if (cur_mode == MODE_PAL8 && !image_over && pad_left == 0 && full_idx.size() != 0)
            return full_idx[$urandom_range(0, full_idx.size() - 1)];
        return $urandom_range(0, 255);
    endfunction

    function automatic void plan_reg(input cfg_idx_t idx, input int unsigned v);
        row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.idx = idx;
        row.val = v;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_word(input logic [1:0] cmd, input logic [7:0] b);
        row_t row;
        row = '{default: '0};
        row.cmd = cmd;
        row.b = b;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_quiet(input logic [1:0] cmd, input logic [7:0] b);
        row_t row;
        row = '{default: '0};
        row.cmd = cmd;
        row.b = b;
        row.typed = 1'b1;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_pixel(input logic [7:0] b, input int unsigned x, y,
                                       input logic [7:0] r, g, bl, a, input bit done);
        row_t row;
        row = '{default: '0};
        row.cmd = CMD_PIXEL;
        row.b = b;
        row.typed = 1'b1;
        row.has = 1'b1;
        row.px = {x[COORD_W-1:0], y[COORD_W-1:0], r, g, bl, a, done};
        plan_q.push_back(row);
    endfunction

    task automatic drive_word(input logic [1:0] cmd, input logic [7:0] b,
                              input bit typed, input bit typed_has, input pixel_t typed_px);
        int unsigned gap;
        pixel_t px;
        bit has;
        gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        has = decode_word(cmd, b, px);
        if (typed) begin
            has = typed_has;
            px = typed_px;
        end
        if (has) want_q.push_back(px);
        s_valid = 1'b1;
        s_cmd = cmd;
        s_data_byte = b;
        words_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(input logic [1:0] cmd, input int unsigned b);
        drive_word(cmd, b[7:0], 1'b0, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (want_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v[CFG_DATA_W-1:0];
        case (idx)
            CFG_PIXEL_MODE:    cur_mode = v[1:0];
            CFG_IMAGE_WIDTH:   cur_width = v[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:  cur_height = v[DIM_W-1:0];
            CFG_PAL_HAS_ALPHA: cur_pal_alpha = v[0];
            CFG_DEFAULT_ALPHA: cur_def_alpha = v[7:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic check_pixel();
        pixel_t got;
        pixel_t exp_px;
        got = {m_pixel_x, m_pixel_y, m_red, m_green, m_blue, m_alpha, m_image_done};
        pixels_seen++;
        if (m_image_done) frames_done++;
        if (want_q.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
                $display("unexpected pixel x=%0d y=%0d rgba=%02h%02h%02h%02h done=%0b",
                         got.x, got.y, got.red, got.green, got.blue, got.alpha, got.done);
            return;
        end
        exp_px = want_q.pop_front();
        if (got !== exp_px) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
                $display("pixel mismatch: expected x=%0d y=%0d rgba=%02h%02h%02h%02h done=%0b",
                         exp_px.x, exp_px.y, exp_px.red, exp_px.green, exp_px.blue,
                         exp_px.alpha, exp_px.done);
                $display("                got      x=%0d y=%0d rgba=%02h%02h%02h%02h done=%0b",
                         got.x, got.y, got.red, got.green, got.blue, got.alpha, got.done);
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side
    initial begin : sink
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                stall = HOLD_OFF;
                hold_req = 1'b0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
            end
            @(negedge aclk);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_pixel();
        end
    end

    initial begin : source
        int unsigned start;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        int unsigned bpp;
        int unsigned pad;
        int unsigned wide_pick [3];
        bit squeeze;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_cmd = CMD_RESTART;
        s_data_byte = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        wide_pick = '{0, MAX_WIDTH_DEF, DIM_ALL};
        cur_mode = MODE_BGR24;
        cur_width = DIM_W'(1);
        cur_height = DIM_W'(1);
        cur_pal_alpha = 1'b1;
        cur_def_alpha = 8'hFF;
        restart_image();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: one 24-bit pixel image, then pad and ignored words
        plan_word(CMD_PIXEL, 8'h00);
        plan_word(CMD_PIXEL, 8'hFF);
        plan_pixel(8'h80, 0, 0, 8'h80, 8'hFF, 8'h00, 8'hFF, 1'b1);
        plan_word(CMD_PIXEL, 8'h11);
        plan_quiet(CMD_PIXEL, 8'h22);
        plan_quiet(CMD_UNUSED, 8'hAA);
        // two 3-byte palette entries
        plan_reg(CFG_PAL_HAS_ALPHA, 0);
        plan_word(CMD_RESTART, 8'h00);
        plan_word(CMD_PALETTE, 8'h01);
        plan_word(CMD_PALETTE, 8'h02);
        plan_word(CMD_PALETTE, 8'h03);
        plan_word(CMD_PALETTE, 8'hFF);
        plan_word(CMD_PALETTE, 8'hFF);
        plan_word(CMD_PALETTE, 8'hFF);
        // 8-bit, width zero, two rows
        plan_reg(CFG_PIXEL_MODE, MODE_PAL8);
        plan_reg(CFG_IMAGE_WIDTH, 0);
        plan_reg(CFG_IMAGE_HEIGHT, 2);
        plan_word(CMD_RESTART, 8'hFF);
        plan_pixel(8'h00, 0, 1, 8'h03, 8'h02, 8'h01, 8'hFF, 1'b0);
        plan_word(CMD_PIXEL, 8'h5A);
        plan_word(CMD_PIXEL, 8'hA5);
        plan_word(CMD_PIXEL, 8'h3C);
        plan_pixel(8'h01, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // unused mode, oversize width, zero height
        plan_reg(CFG_PIXEL_MODE, MODE_UNUSED);
        plan_reg(CFG_IMAGE_WIDTH, DIM_ALL);
        plan_reg(CFG_IMAGE_HEIGHT, 0);
        plan_reg(CFG_DEFAULT_ALPHA, 0);
        plan_word(CMD_RESTART, 8'h00);
        plan_word(CMD_PIXEL, 8'hFF);
        plan_word(CMD_PIXEL, 8'h00);
        plan_word(CMD_PIXEL, 8'hFF);
        plan_pixel(8'h00, 0, 0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);

        foreach (plan_q[i]) begin
            if (plan_q[i].is_reg) begin
                drain();
                write_reg(cfg_idx_t'(plan_q[i].idx), plan_q[i].val);
            end else begin
                drive_word(plan_q[i].cmd, plan_q[i].b, plan_q[i].typed, plan_q[i].has,
                           plan_q[i].px);
            end
        end

        // full palette with surplus bytes
        drain();
        write_reg(CFG_PAL_HAS_ALPHA, 0);
        send(CMD_RESTART, $urandom_range(0, 255));
        repeat (3 * PALETTE_ENTRIES_DEF + 6) send(CMD_PALETTE, $urandom_range(0, 255));

        start = words_sent;
        while (words_sent - start < WORD_GOAL) begin
            phases++;
            calm = ($urandom_range(0, 3) == 0);
            squeeze = (phases == 1);
            drain();
            if ($urandom_range(0, 4) == 0 && !squeeze) begin
                // partial palette reload
                write_reg(CFG_PAL_HAS_ALPHA, $urandom_range(0, 1));
                send(CMD_RESTART, $urandom_range(0, 255));
                n = (cur_pal_alpha ? 4 : 3) * $urandom_range(1, 12);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 19) == 0) send(CMD_UNUSED, $urandom_range(0, 255));
                    send(CMD_PALETTE, $urandom_range(0, 255));
                end
            end else begin
                if ($urandom_range(0, 2) != 0) begin
                    write_reg(CFG_PIXEL_MODE,
                              ($urandom_range(0, 9) == 0) ? MODE_UNUSED : $urandom_range(0, 2));
                    write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 11) == 0) ?
                              wide_pick[$urandom_range(0, 2)] : $urandom_range(1, 9));
                    write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 11) == 0) ?
                              (($urandom_range(0, 1) == 0) ? 0 : MAX_HEIGHT_DEF) :
                              $urandom_range(1, 4));
                    write_reg(CFG_PAL_HAS_ALPHA, $urandom_range(0, 1));
                    write_reg(CFG_DEFAULT_ALPHA, ($urandom_range(0, 7) == 0) ?
                              (($urandom_range(0, 1) == 0) ? 0 : 255) : $urandom_range(0, 255));
                end
                if (squeeze) begin
                    // stall the result side while the words keep coming
                    write_reg(CFG_PIXEL_MODE, MODE_BGR24);
                    write_reg(CFG_IMAGE_WIDTH, 5);
                    write_reg(CFG_IMAGE_HEIGHT, 4);
                    calm = 1'b1;
                    hold_req = 1'b1;
                end
                if (squeeze || $urandom_range(0, 9) != 0) send(CMD_RESTART, $urandom_range(0, 255));
                w = eff_dim(cur_width, MAX_WIDTH_DEF);
                h = eff_dim(cur_height, MAX_HEIGHT_DEF);
                bpp = bytes_per_px();
                pad = (4 - ((w * bpp) % 4)) % 4;
                n = h * (w * bpp + pad);
                if (n > LONG_RUN) begin
                    n = $urandom_range(20, 60);
                end else begin
                    n += $urandom_range(0, 2);
                end
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 49))
                        0: send(CMD_UNUSED, $urandom_range(0, 255));
                        1: send(CMD_PALETTE, $urandom_range(0, 255));
                        2: begin
                            if (!squeeze && $urandom_range(0, 3) == 0) begin
                                send(CMD_RESTART, $urandom_range(0, 255));
                            end else begin
                                send(CMD_PIXEL, safe_pixel_byte());
                            end
                        end
                        default: send(CMD_PIXEL, safe_pixel_byte());
                    endcase
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (want_q.size() != 0) begin
            $display("%0d expected pixels never came out", want_q.size());
            mismatches += want_q.size();
        end
        $display("drove %0d words over %0d random phases plus directed and full palette loads",
                 words_sent, phases);
        $display("checked %0d pixels, %0d completed images, %0d mismatches",
                 pixels_seen, frames_done, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/bmpd_pkg.sv
src/bmpd_ram.sv
src/bmpd_raster.sv
src/bmp_pixel_stream_decoder_top.sv
dv/testbench.sv
